FILE: design/assert_macros.svh
// Assertion helpers used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("%m");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("%m");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: design/lsss_pkg.sv
package lsss_pkg;
  localparam int MAX_SCAN_POINTS_DEF = 4096;
  localparam int OBJECT_SLOTS_DEF    = 2;
  localparam int ANGLE_FRAC_BITS_DEF = 12;

  localparam logic [2:0] REG_MIN_RANGE = 3'd0;
  localparam logic [2:0] REG_MAX_RANGE = 3'd1;
  localparam logic [2:0] REG_ANG_GAP   = 3'd2;
  localparam logic [2:0] REG_RNG_GAP   = 3'd3;
  localparam logic [2:0] REG_MIN_PTS   = 3'd4;
  localparam logic [2:0] REG_MIN_WIDTH = 3'd5;
  localparam logic [2:0] REG_MAX_WIDTH = 3'd6;

  localparam int SUM_W = 28;

  // divider request/response
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [12:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;
endpackage

FILE: design/lsss_divider.sv
// Restoring divider, one quotient bit per cycle
module lsss_divider
  import lsss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  localparam int CW = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [13:0]      rem_r, rem_nxt;
  logic [12:0]      dvs_r, dvs_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [14:0]      trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[SUM_W-1]} - {2'b0, dvs_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = CW'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      if (!trial[14]) begin
        rem_nxt = trial[13:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[12:0], quo_r[SUM_W-1]};
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule

FILE: design/lidar_scan_segment_selector_top.sv
// Channel | Dir | tdata (low bit first)                   | tuser
// in_     | in  | sample_angle[14:0], sample_range[30:15]  | -        tlast=end_of_scan
// out_    | out | found[0], centre_angle[15:1], range[31:16]| slot    tlast=last
// cfg_    | in  | index 3 bits, data 16 bits                | -
// A point that is rejected or simply extends a segment passes through ST_IDLE and ST_PT.
// A point that closes a segment with enough points uses the shared divider (mean
// range), then a multiply (width) and, if the width fits, the divider (mean angle).
// End of scan adds one closing and one result per slot; each result is held
// on out_tdata until out_tready, and no point is taken meanwhile.
// rst_n is synchronous; reset restores register defaults and clears a scan.
`include "assert_macros.svh"
module lidar_scan_segment_selector_top
  import lsss_pkg::*;
#(
  parameter int OBJECT_SLOTS    = OBJECT_SLOTS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // sample_angle[14:0], sample_range[30:15]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // found[0], centre_angle[15:1], centre_range[31:16]
  output logic        out_tuser,  // slot
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int SW = (OBJECT_SLOTS > 1) ? $clog2(OBJECT_SLOTS) : 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PT    = 4'd1;
  localparam logic [3:0] ST_CLOSE = 4'd2;
  localparam logic [3:0] ST_DIVR  = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_WID   = 4'd5;
  localparam logic [3:0] ST_DIVA  = 4'd6;
  localparam logic [3:0] ST_INS   = 4'd7;
  localparam logic [3:0] ST_OPEN  = 4'd8;
  localparam logic [3:0] ST_EMIT  = 4'd9;
  localparam logic [3:0] ST_WAIT  = 4'd10;

  logic [3:0] st_r, st_nxt;

  // configuration registers
  logic [15:0] min_range_r, max_range_r, rng_gap_r, min_width_r, max_width_r;
  logic [14:0] ang_gap_r;
  logic [12:0] min_pts_r;

  // current point
  logic signed [14:0] a_r;
  logic [15:0] r_r;
  logic        eos_r;

  // segment state
  logic signed [14:0] prev_a_r, first_a_r;
  logic [15:0] prev_r_r, seg_near_r;
  logic        open_r;
  logic [12:0] cnt_r;
  logic signed [SUM_W-1:0] asum_r;
  logic [SUM_W-1:0] rsum_r;

  // closing work
  logic [15:0] mean_r;
  logic [31:0] prod_r;
  logic        neg_r;
  logic signed [14:0] cang_r;

  // slots
  logic               bv_r   [OBJECT_SLOTS];
  logic [15:0]        bn_r   [OBJECT_SLOTS];
  logic signed [14:0] ba_r   [OBJECT_SLOTS];
  logic [15:0]        br_r   [OBJECT_SLOTS];
  logic [SW-1:0]      emit_r;

  div_req_t dreq;
  div_rsp_t drsp;
  lsss_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic signed [15:0] da_s;
  logic [14:0] da;
  logic [15:0] dr;
  logic        keep, join_ok;
  logic [14:0] wdiff;
  logic [15:0] width;
  logic [SW:0] ins_pos;
  logic [SUM_W-1:0] amag;
  logic        scan_done;

  always_comb begin
    da_s = 16'(a_r) - 16'(prev_a_r);
    da   = da_s[15] ? 15'(-da_s) : da_s[14:0];
    dr   = (r_r >= prev_r_r) ? r_r - prev_r_r : prev_r_r - r_r;
    keep = (r_r > min_range_r) && (r_r < max_range_r);
    join_ok = open_r && (da <= ang_gap_r) && (dr <= rng_gap_r)
              && (32'(cnt_r) < 32'(MAX_SCAN_POINTS_DEF));
    wdiff = (prev_a_r >= first_a_r) ? 15'(prev_a_r - first_a_r) : 15'(first_a_r - prev_a_r);
    width = ((prod_r >> ANGLE_FRAC_BITS) > 32'hFFFF) ? 16'hFFFF
            : 16'(prod_r >> ANGLE_FRAC_BITS);
    amag  = asum_r[SUM_W-1] ? SUM_W'(-asum_r) : SUM_W'(asum_r);
    ins_pos = (SW+1)'(OBJECT_SLOTS);
    for (int i = OBJECT_SLOTS - 1; i >= 0; i--) begin
      if (!bv_r[i] || seg_near_r < bn_r[i]) ins_pos = (SW+1)'(i);
    end
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    dreq   = '0;
    unique case (st_r)
      ST_IDLE:  if (in_tvalid) st_nxt = ST_PT;
      ST_PT: begin
        if (keep && !join_ok) st_nxt = ST_CLOSE;
        else if (eos_r)       st_nxt = ST_CLOSE;
        else                  st_nxt = ST_IDLE;
      end
      ST_CLOSE: begin
        if (open_r && cnt_r != '0 && cnt_r > min_pts_r) begin
          dreq.start = 1'b1;
          dreq.dividend = rsum_r;
          dreq.divisor = cnt_r;
          st_nxt = ST_DIVR;
        end else st_nxt = scan_done ? ST_EMIT : ST_OPEN;
      end
      ST_DIVR:  if (drsp.done) st_nxt = ST_MUL;
      ST_MUL:   st_nxt = ST_WID;
      ST_WID: begin
        if (width < min_width_r || width > max_width_r)
          st_nxt = scan_done ? ST_EMIT : ST_OPEN;
        else begin
          dreq.start = 1'b1;
          dreq.dividend = amag;
          dreq.divisor = cnt_r;
          st_nxt = ST_DIVA;
        end
      end
      ST_DIVA:  if (drsp.done) st_nxt = ST_INS;
      ST_INS:   st_nxt = scan_done ? ST_EMIT : ST_OPEN;
      ST_OPEN:  st_nxt = eos_r ? ST_CLOSE : ST_IDLE;
      ST_EMIT:  st_nxt = ST_WAIT;
      ST_WAIT: begin
        if (out_tready) begin
          if (32'(emit_r) == OBJECT_SLOTS - 1) st_nxt = ST_IDLE;
          else st_nxt = ST_EMIT;
        end
      end
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // scan_done: the closing in progress is the end-of-scan closing
  logic fin_r;
  assign scan_done = fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      min_range_r <= 16'd100; max_range_r <= 16'd800; ang_gap_r <= 15'd614;
      rng_gap_r <= 16'd300; min_pts_r <= 13'd5; min_width_r <= 16'd100;
      max_width_r <= 16'd600;
      open_r <= 1'b0; cnt_r <= '0; prev_a_r <= '0; prev_r_r <= '0;
      first_a_r <= '0; asum_r <= '0; rsum_r <= '0; seg_near_r <= 16'hFFFF;
      fin_r <= 1'b0; emit_r <= '0;
      for (int i = 0; i < OBJECT_SLOTS; i++) begin
        bv_r[i] <= 1'b0; bn_r[i] <= 16'hFFFF;
      end
    end else begin
      st_r <= st_nxt;
      // take register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MIN_RANGE: min_range_r <= cfg_data;
          REG_MAX_RANGE: max_range_r <= cfg_data;
          REG_ANG_GAP:   ang_gap_r   <= cfg_data[14:0];
          REG_RNG_GAP:   rng_gap_r   <= cfg_data;
          REG_MIN_PTS:   min_pts_r   <= cfg_data[12:0];
          REG_MIN_WIDTH: min_width_r <= cfg_data;
          REG_MAX_WIDTH: max_width_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (st_r)
        ST_IDLE: if (in_tvalid) begin
          a_r <= in_tdata[14:0]; r_r <= in_tdata[30:15]; eos_r <= in_tlast;
          fin_r <= 1'b0;
        end
        ST_PT: begin
          if (keep && join_ok) begin
            cnt_r  <= cnt_r + 1'b1;
            asum_r <= asum_r + SUM_W'(a_r);
            rsum_r <= rsum_r + SUM_W'(r_r);
            if (r_r < seg_near_r) seg_near_r <= r_r;
            prev_a_r <= a_r; prev_r_r <= r_r;
          end else if (!keep) begin
            fin_r <= eos_r;
          end
        end
        ST_DIVR: if (drsp.done) mean_r <= drsp.quotient[15:0];
        ST_MUL:  prod_r <= 32'(wdiff) * 32'(mean_r);
        ST_CLOSE: if (!(open_r && cnt_r != '0 && cnt_r > min_pts_r)) open_r <= 1'b0;
        ST_WID:  neg_r <= asum_r[SUM_W-1];
        ST_DIVA: if (drsp.done)
          cang_r <= neg_r ? 15'(-drsp.quotient[14:0]) : drsp.quotient[14:0];
        ST_INS: begin
          open_r <= 1'b0;
          if (32'(ins_pos) < OBJECT_SLOTS) begin
            for (int j = OBJECT_SLOTS - 1; j > 0; j--) begin
              if (32'(j) > 32'(ins_pos)) begin
                bv_r[j] <= bv_r[j-1]; bn_r[j] <= bn_r[j-1];
                ba_r[j] <= ba_r[j-1]; br_r[j] <= br_r[j-1];
              end
            end
            bv_r[ins_pos[SW-1:0]] <= 1'b1;
            bn_r[ins_pos[SW-1:0]] <= seg_near_r;
            ba_r[ins_pos[SW-1:0]] <= cang_r;
            br_r[ins_pos[SW-1:0]] <= mean_r;
          end
        end
        ST_OPEN: begin
          // a kept point that failed to join opens the next segment
          open_r <= 1'b1; cnt_r <= 13'd1; first_a_r <= a_r;
          asum_r <= SUM_W'(a_r); rsum_r <= SUM_W'(r_r); seg_near_r <= r_r;
          prev_a_r <= a_r; prev_r_r <= r_r;
          fin_r <= eos_r;
        end
        ST_EMIT: ;
        ST_WAIT: if (out_tready) begin
          if (32'(emit_r) == OBJECT_SLOTS - 1) begin
            // clear the scan
            emit_r <= '0; open_r <= 1'b0; cnt_r <= '0; prev_a_r <= '0;
            prev_r_r <= '0; first_a_r <= '0; asum_r <= '0; rsum_r <= '0;
            seg_near_r <= 16'hFFFF; fin_r <= 1'b0;
            for (int i = 0; i < OBJECT_SLOTS; i++) begin
              bv_r[i] <= 1'b0; bn_r[i] <= 16'hFFFF;
            end
          end else emit_r <= emit_r + 1'b1;
        end
        default: ;
      endcase
      // end-of-scan point that did not open via ST_OPEN route
      if (st_r == ST_PT && keep && join_ok) fin_r <= eos_r;
    end
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = (st_r == ST_WAIT);
  assign out_tuser  = emit_r[0];
  assign out_tlast  = (32'(emit_r) == OBJECT_SLOTS - 1);
  assign out_tdata  = {bv_r[emit_r] ? br_r[emit_r] : 16'd0,
                       bv_r[emit_r] ? ba_r[emit_r] : 15'd0, bv_r[emit_r]};

  `ASSERT_IMPLIES(a_out_busy, clk, rst_n, out_tvalid, !in_tready)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_IMPLIES(a_div_idle, clk, rst_n, in_tready, !dreq.start)
endmodule
